/* rtl/core/sktcw_pkg.sv */
// Shared types and fixed constants for the shear-to-convergence weight unit.
// Depends on nothing; imported by every module of the block except sktcw_div.
package sktcw_pkg;

  localparam int IDX_W       = 10;   // grid index width
  localparam int COEF_W      = 32;   // shear coefficient width
  localparam int OUT_W       = 48;   // result field width
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 192;
  localparam int RECIP_SHIFT = 24;   // scale of the reciprocal used for index folding
  localparam int QDEPTH      = 2;    // front-to-back queue depth

  // first_re sits in the lowest bits
  typedef struct packed {
    logic signed [COEF_W-1:0] second_im;
    logic signed [COEF_W-1:0] second_re;
    logic signed [COEF_W-1:0] first_im;
    logic signed [COEF_W-1:0] first_re;
  } coefs_t;

  typedef struct packed {
    logic zero;    // in-plane wavenumber is zero
    logic yneg;    // folded y is negative
    logic f1neg;   // y^2 > x^2
  } mode_flags_t;

endpackage

/* rtl/core/sktcw_front.sv */
// Front end: folds grid indices, forms squares, numerators and denominator.
// Six register stages moving together under en. Uses sktcw_pkg.
module sktcw_front import sktcw_pkg::*; #(
  parameter int GRID_SIZE = 1024,
  parameter int AW        = 10,
  parameter int SQW       = 20,
  parameter int KVW       = 21,
  parameter int K2W       = 22,
  parameter int DENW      = 42,
  parameter int NUMW      = 43
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              take,
  input  logic [IDX_W-1:0]  x_in,
  input  logic [IDX_W-1:0]  row_in,
  input  logic [IDX_W-1:0]  plane_in,
  input  coefs_t            coefs_in,
  output logic              valid_o,
  output logic [NUMW-1:0]   num1_o,
  output logic [NUMW-1:0]   num2_o,
  output logic [DENW-1:0]   den_o,
  output mode_flags_t       flags_o,
  output coefs_t            coefs_o
);

  localparam int PRW = IDX_W + RECIP_SHIFT;
  localparam int XYW = IDX_W + AW;
  localparam int P1W = SQW + K2W;
  localparam int P2W = XYW + K2W;
  localparam logic [PRW-1:0] RECIP  = PRW'((2**RECIP_SHIFT + GRID_SIZE - 1) / GRID_SIZE);
  localparam logic [PRW-1:0] GRID_K = PRW'(GRID_SIZE);
  localparam logic [PRW-1:0] HALF_K = PRW'(GRID_SIZE / 2);

  logic va, vb, vc, vd, ve, vf;

  logic [IDX_W-1:0] a_x, a_jy, a_jz, a_qy, a_qz;
  coefs_t           a_co;
  logic [IDX_W-1:0] b_x, b_ry, b_rz;
  coefs_t           b_co;
  logic [IDX_W-1:0] c_x;
  logic [AW-1:0]    c_ay, c_az;
  logic             c_yneg;
  coefs_t           c_co;
  logic [IDX_W-1:0] d_x;
  logic [AW-1:0]    d_ay;
  logic [SQW-1:0]   d_x2, d_y2, d_z2;
  logic             d_yneg;
  coefs_t           d_co;
  logic [KVW-1:0]   e_kv2;
  logic [K2W-1:0]   e_k2;
  logic [SQW-1:0]   e_d;
  logic [XYW-1:0]   e_xay;
  mode_flags_t      e_flags;
  coefs_t           e_co;

  logic [PRW-1:0]   prod_y, prod_z, rem_y, rem_z, ext_y, ext_z;
  logic [AW-1:0]    ay_next, az_next;
  logic             yneg_next;
  logic [KVW-1:0]   kv2_next;
  logic [K2W-1:0]   k2_next;
  logic [SQW-1:0]   d_next;
  logic             f1neg_next;
  logic [P1W-1:0]   p1;
  logic [P2W-1:0]   p2;

  // floor(j / GRID_SIZE) by reciprocal; exact for 10-bit j
  assign prod_y = PRW'(row_in) * RECIP;
  assign prod_z = PRW'(plane_in) * RECIP;
  assign rem_y  = PRW'(a_jy) - PRW'(a_qy) * GRID_K;
  assign rem_z  = PRW'(a_jz) - PRW'(a_qz) * GRID_K;
  assign ext_y  = PRW'(b_ry);
  assign ext_z  = PRW'(b_rz);

  always_comb begin
    if (ext_y <= HALF_K) begin
      ay_next   = AW'(b_ry);
      yneg_next = 1'b0;
    end else begin
      ay_next   = AW'(GRID_K - ext_y);
      yneg_next = 1'b1;
    end
    if (ext_z <= HALF_K) begin
      az_next = AW'(b_rz);
    end else begin
      az_next = AW'(GRID_K - ext_z);
    end
  end

  always_comb begin
    kv2_next   = KVW'(d_x2) + KVW'(d_y2);
    k2_next    = K2W'(kv2_next) + K2W'(d_z2);
    f1neg_next = d_y2 > d_x2;
    d_next     = f1neg_next ? (d_y2 - d_x2) : (d_x2 - d_y2);
  end

  assign p1 = P1W'(e_d) * P1W'(e_k2);
  assign p2 = P2W'(e_xay) * P2W'(e_k2);

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf} <= '0;
    end else if (en) begin
      va <= take;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x  <= x_in;
      a_jy <= row_in;
      a_jz <= plane_in;
      a_qy <= prod_y[PRW-1:RECIP_SHIFT];
      a_qz <= prod_z[PRW-1:RECIP_SHIFT];
      a_co <= coefs_in;

      b_x  <= a_x;
      b_ry <= rem_y[IDX_W-1:0];
      b_rz <= rem_z[IDX_W-1:0];
      b_co <= a_co;

      c_x    <= b_x;
      c_ay   <= ay_next;
      c_az   <= az_next;
      c_yneg <= yneg_next;
      c_co   <= b_co;

      d_x    <= c_x;
      d_ay   <= c_ay;
      d_x2   <= SQW'(c_x) * SQW'(c_x);
      d_y2   <= SQW'(c_ay) * SQW'(c_ay);
      d_z2   <= SQW'(c_az) * SQW'(c_az);
      d_yneg <= c_yneg;
      d_co   <= c_co;

      e_kv2         <= kv2_next;
      e_k2          <= k2_next;
      e_d           <= d_next;
      e_xay         <= XYW'(d_x) * XYW'(d_ay);
      e_flags.zero  <= (kv2_next == '0);
      e_flags.yneg  <= d_yneg;
      e_flags.f1neg <= f1neg_next;
      e_co          <= d_co;

      den_o   <= DENW'(e_kv2) * DENW'(e_kv2);
      num1_o  <= NUMW'({p1, 1'b0});
      num2_o  <= NUMW'({p2, 2'b00});
      flags_o <= e_flags;
      coefs_o <= e_co;
    end
  end

  assign valid_o = vf;

endmodule

/* rtl/core/sktcw_queue.sv */
// Two-entry queue between front and back end.
// Generic payload vector; uses sktcw_pkg for the depth.
module sktcw_queue import sktcw_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [QDEPTH];
  logic         wp, rp;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  assign full     = (count == 2'(QDEPTH));
  assign nonempty = (count != '0);
  assign pop_data = mem[rp];

endmodule

/* rtl/core/sktcw_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Starts from a partial remainder below the divisor. No package use.
module sktcw_div #(
  parameter int DENW = 42,
  parameter int QW   = 38
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DENW-1:0] den_in,
  input  logic [DENW-1:0] rem_in,
  input  logic [QW-1:0]   dvd_in,
  output logic [QW-1:0]   quo_out
);

  logic [DENW-1:0] rem [QW-1];
  logic [DENW-1:0] dn  [QW-1];
  logic [QW-1:0]   shr [QW];

  logic [DENW-1:0] rs [QW];
  logic [DENW-1:0] ds [QW];
  logic [QW-1:0]   ss [QW];
  logic [DENW:0]   tt [QW];
  logic [DENW:0]   df [QW];
  logic [QW-1:0]   ge;

  assign rs[0] = rem_in;
  assign ds[0] = den_in;
  assign ss[0] = dvd_in;

  for (genvar g = 1; g < QW; g++) begin : g_link
    assign rs[g] = rem[g-1];
    assign ds[g] = dn[g-1];
    assign ss[g] = shr[g-1];
  end

  // shr holds unused dividend bits on top, quotient bits filling from below
  for (genvar g = 0; g < QW; g++) begin : g_cmp
    assign tt[g] = {rs[g], ss[g][QW-1]};
    assign ge[g] = tt[g] >= {1'b0, ds[g]};
    assign df[g] = tt[g] - {1'b0, ds[g]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW - 1; i++) begin
        rem[i] <= ge[i] ? df[i][DENW-1:0] : tt[i][DENW-1:0];
        dn[i]  <= ds[i];
      end
      for (int i = 0; i < QW; i++) begin
        shr[i] <= {ss[i][QW-2:0], ge[i]};
      end
    end
  end

  assign quo_out = shr[QW-1];

endmodule

/* rtl/core/sktcw_back.sv */
// Back end: two dividers for f1/f2, rounding, split multiplies, sums,
// shift and 48-bit saturation into the output register. Uses sktcw_pkg.
module sktcw_back import sktcw_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int AW        = 10,
  parameter int DENW      = 42,
  parameter int NUMW      = 43
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [NUMW-1:0]         num1,
  input  logic [NUMW-1:0]         num2,
  input  logic [DENW-1:0]         den,
  input  mode_flags_t             flags,
  input  coefs_t                  coefs,
  output logic                    m_valid,
  input  logic                    m_ready,
  output logic signed [OUT_W-1:0] kappa_re,
  output logic signed [OUT_W-1:0] kappa_im,
  output logic signed [OUT_W-1:0] beta_re,
  output logic signed [OUT_W-1:0] beta_im,
  output logic                    saturated
);

  localparam int FMW = 2 * AW + FRAC_BITS + 1;   // factor magnitude width
  localparam int QW  = FMW + 1;                   // quotient carries one extra bit for rounding
  localparam int NVW = NUMW + FRAC_BITS + 1;
  localparam int FS  = FMW + 1;
  localparam int LW  = FS / 2;
  localparam int HW  = FS - LW;
  localparam int PLW = LW + 1 + COEF_W;
  localparam int PHW = HW + COEF_W;
  localparam int EW  = (FS + COEF_W + 1 > FRAC_BITS + OUT_W + 2) ?
                       FS + COEF_W + 1 : FRAC_BITS + OUT_W + 2;
  localparam logic signed [EW-1:0] OMAX = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [EW-1:0] OMIN = {{(EW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic adv;
  assign adv   = !m_valid || m_ready;
  assign q_pop = adv && q_valid;

  // divider operands: num * 2^(FRAC_BITS+1) / den
  logic [NVW-1:0]  n1x, n2x;
  logic [QW-1:0]   q1, q2;
  assign n1x = {num1, {(FRAC_BITS+1){1'b0}}};
  assign n2x = {num2, {(FRAC_BITS+1){1'b0}}};

  sktcw_div #(.DENW(DENW), .QW(QW)) u_div1 (
    .clk     (clk),
    .en      (adv),
    .den_in  (den),
    .rem_in  (DENW'(n1x >> QW)),
    .dvd_in  (n1x[QW-1:0]),
    .quo_out (q1)
  );

  sktcw_div #(.DENW(DENW), .QW(QW)) u_div2 (
    .clk     (clk),
    .en      (adv),
    .den_in  (den),
    .rem_in  (DENW'(n2x >> QW)),
    .dvd_in  (n2x[QW-1:0]),
    .quo_out (q2)
  );

  logic [QW-1:0] vd;
  mode_flags_t   fl_pipe [QW];
  coefs_t        co_pipe [QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_pipe[0] <= flags;
      co_pipe[0] <= coefs;
      for (int i = 1; i < QW; i++) begin
        fl_pipe[i] <= fl_pipe[i-1];
        co_pipe[i] <= co_pipe[i-1];
      end
    end
  end

  // round half up: (floor(2t) + 1) / 2
  logic [QW:0]            q1p, q2p;
  logic signed [FS-1:0]   f1v, f2v;
  mode_flags_t            fl_end;
  assign q1p    = {1'b0, q1} + (QW+1)'(1);
  assign q2p    = {1'b0, q2} + (QW+1)'(1);
  assign f1v    = $signed({1'b0, q1p[FMW:1]});
  assign f2v    = $signed({1'b0, q2p[FMW:1]});
  assign fl_end = fl_pipe[QW-1];

  logic                 vr, vm, vs1, vs2;
  logic signed [FS-1:0] f1r, f2r, nf2r;
  coefs_t               cor;

  logic signed [FS-1:0]     fa [8];
  logic signed [COEF_W-1:0] ca [8];
  logic signed [PLW-1:0]    pl [8];
  logic signed [PHW-1:0]    ph [8];
  logic signed [EW-1:0]     tm [8];
  logic signed [EW-1:0]     sm [4];

  // product pairs: kappa_re, kappa_im, beta_re, beta_im
  always_comb begin
    fa[0] = f1r;  ca[0] = cor.first_re;
    fa[1] = f2r;  ca[1] = cor.second_re;
    fa[2] = f1r;  ca[2] = cor.first_im;
    fa[3] = f2r;  ca[3] = cor.second_im;
    fa[4] = nf2r; ca[4] = cor.first_re;
    fa[5] = f1r;  ca[5] = cor.second_re;
    fa[6] = nf2r; ca[6] = cor.first_im;
    fa[7] = f1r;  ca[7] = cor.second_im;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fl_end.zero) begin
        f1r  <= '0;
        f2r  <= '0;
        nf2r <= '0;
      end else begin
        f1r  <= fl_end.f1neg ? -f1v : f1v;
        f2r  <= fl_end.yneg ? -f2v : f2v;
        nf2r <= fl_end.yneg ? f2v : -f2v;
      end
      cor <= co_pipe[QW-1];
      for (int i = 0; i < 8; i++) begin
        pl[i] <= PLW'($signed({1'b0, fa[i][LW-1:0]})) * PLW'(ca[i]);
        ph[i] <= PHW'($signed(fa[i][FS-1:LW])) * PHW'(ca[i]);
        tm[i] <= (EW'(ph[i]) <<< LW) + EW'(pl[i]);
      end
      for (int k = 0; k < 4; k++) begin
        sm[k] <= tm[2*k] + tm[2*k+1];
      end
    end
  end

  logic signed [EW-1:0]    sh [4];
  logic signed [OUT_W-1:0] res_next [4];
  logic [3:0]              clip;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sh[k] = sm[k] >>> FRAC_BITS;
      clip[k] = 1'b1;
      if (sh[k] > OMAX) begin
        res_next[k] = OMAX[OUT_W-1:0];
      end else if (sh[k] < OMIN) begin
        res_next[k] = OMIN[OUT_W-1:0];
      end else begin
        res_next[k] = sh[k][OUT_W-1:0];
        clip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd      <= '0;
      vr      <= 1'b0;
      vm      <= 1'b0;
      vs1     <= 1'b0;
      vs2     <= 1'b0;
      m_valid <= 1'b0;
    end else if (adv) begin
      vd      <= {vd[QW-2:0], q_pop};
      vr      <= vd[QW-1];
      vm      <= vr;
      vs1     <= vm;
      vs2     <= vs1;
      m_valid <= vs2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kappa_re  <= res_next[0];
      kappa_im  <= res_next[1];
      beta_re   <= res_next[2];
      beta_im   <= res_next[3];
      saturated <= |clip;
    end
  end

endmodule

/* rtl/core/shear_to_convergence_weight_unit.sv */
// Shear-to-convergence weight unit, top level.
// Input beat on s_axis: grid index (x, row, plane) and two complex shear
// coefficients. Output beat on m_axis: kappa and beta pairs, 48 bits each,
// with the saturation flag on m_axis_tuser. One result beat per input beat,
// in order.
// Throughput: one beat per cycle while m_axis_tready is held high. The
// pipeline depth is set by the two pipelined dividers, one quotient bit per
// stage, for f1 and f2.
// The front end (index folding, squares, numerators) feeds a two-entry
// queue; it stalls only when that queue is full, so s_axis_tready does not
// depend on m_axis_tready in the same cycle. The back end stalls as a whole
// while the output register holds a beat that m_axis has not taken.
// Synchronous reset clears all valid flags and the queue; no beat is
// presented on the cycle after reset.
// Depends on sktcw_pkg, sktcw_front, sktcw_queue, sktcw_div, sktcw_back.
module shear_to_convergence_weight_unit import sktcw_pkg::*; #(
  parameter int GRID_SIZE = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // wave_x, row_index, plane_index, first_re, first_im, second_re, second_im
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // kappa_re, kappa_im, beta_re, beta_im
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                   m_axis_tuser
);

  localparam int AW   = $clog2(GRID_SIZE / 2 + 1);
  localparam int SQW  = (2 * AW > 2 * IDX_W) ? 2 * AW : 2 * IDX_W;
  localparam int KVW  = SQW + 1;
  localparam int K2W  = KVW + 1;
  localparam int DENW = 2 * KVW;
  localparam int N1W  = SQW + K2W + 1;
  localparam int N2W  = IDX_W + AW + K2W + 2;
  localparam int NUMW = (N1W > N2W) ? N1W : N2W;
  localparam int QDW  = 2 * NUMW + DENW + $bits(mode_flags_t) + $bits(coefs_t);

  logic             take, q_full, q_nonempty, q_pop, f_valid;
  logic [NUMW-1:0]  f_num1, f_num2, b_num1, b_num2;
  logic [DENW-1:0]  f_den, b_den;
  mode_flags_t      f_flags, b_flags;
  coefs_t           f_coefs, b_coefs;
  logic [QDW-1:0]   q_data;
  logic signed [OUT_W-1:0] kappa_re, kappa_im, beta_re, beta_im;

  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  sktcw_front #(
    .GRID_SIZE (GRID_SIZE),
    .AW        (AW),
    .SQW       (SQW),
    .KVW       (KVW),
    .K2W       (K2W),
    .DENW      (DENW),
    .NUMW      (NUMW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (!q_full),
    .take     (take),
    .x_in     (s_axis_tdata[9:0]),
    .row_in   (s_axis_tdata[19:10]),
    .plane_in (s_axis_tdata[29:20]),
    .coefs_in (coefs_t'(s_axis_tdata[157:30])),
    .valid_o  (f_valid),
    .num1_o   (f_num1),
    .num2_o   (f_num2),
    .den_o    (f_den),
    .flags_o  (f_flags),
    .coefs_o  (f_coefs)
  );

  sktcw_queue #(.W(QDW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && !q_full),
    .push_data ({f_num1, f_num2, f_den, f_flags, f_coefs}),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_data)
  );

  assign {b_num1, b_num2, b_den, b_flags, b_coefs} = q_data;

  sktcw_back #(
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW),
    .DENW      (DENW),
    .NUMW      (NUMW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_pop     (q_pop),
    .num1      (b_num1),
    .num2      (b_num2),
    .den       (b_den),
    .flags     (b_flags),
    .coefs     (b_coefs),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .kappa_re  (kappa_re),
    .kappa_im  (kappa_im),
    .beta_re   (beta_re),
    .beta_im   (beta_im),
    .saturated (m_axis_tuser)
  );

  assign m_axis_tdata = {beta_im, beta_re, kappa_im, kappa_re};

endmodule

/* rtl/core/sktcw_check.sv */
// Port-level checks for the shear-to-convergence weight unit, bound to the
// top level. Uses sktcw_pkg for port widths.
module sktcw_check import sktcw_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  localparam logic [OUT_W-1:0] SMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SMIN = {1'b1, {(OUT_W-1){1'b0}}};

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // a clamped beat has at least one field at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[47:0] == SMAX || m_axis_tdata[47:0] == SMIN ||
      m_axis_tdata[95:48] == SMAX || m_axis_tdata[95:48] == SMIN ||
      m_axis_tdata[143:96] == SMAX || m_axis_tdata[143:96] == SMIN ||
      m_axis_tdata[191:144] == SMAX || m_axis_tdata[191:144] == SMIN)
    else $error("saturation flag without a clamped field");

endmodule

bind shear_to_convergence_weight_unit sktcw_check u_sktcw_check (.*);
